// ===== hw/rtl/hevc_idr_access_unit_checker_core_macros.svh =====
// Assertion macros shared by the IDR access unit checker modules
`ifndef HEVC_IDR_ACCESS_UNIT_CHECKER_CORE_MACROS_SVH
`define HEVC_IDR_ACCESS_UNIT_CHECKER_CORE_MACROS_SVH

// Check an implication on every rising edge of clk outside reset
`define HIAC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk outside reset
`define HIAC_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/hiac_pkg.sv =====
// Types and constants for the HEVC IDR access unit checker
package hiac_pkg;

	localparam int unsigned LEN_SIZE_W = 3;
	localparam logic [LEN_SIZE_W-1:0] LEN_SIZE_RESET = 3'd4;
	localparam logic [LEN_SIZE_W-1:0] LEN_SIZE_MAX = 3'd4;

	localparam logic [5:0] NAL_IDR_W_RADL = 6'd19;
	localparam logic [5:0] NAL_IDR_N_LP = 6'd20;

	localparam logic [1:0] ST_IDR = 2'd0;
	localparam logic [1:0] ST_NO_VCL = 2'd1;
	localparam logic [1:0] ST_NON_IDR = 2'd2;
	localparam logic [1:0] ST_BAD_LEN = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic       is_idr;
		logic [1:0] status;
	} out_item_t;

endpackage

// ===== hw/rtl/hiac_nal_parser.sv =====
// Per-byte NAL length and type parser holding the access unit state
module hiac_nal_parser import hiac_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  in_item_t              item,
	input  logic [LEN_SIZE_W-1:0] length_size,
	output out_item_t             result
);

	`include "hevc_idr_access_unit_checker_core_macros.svh"

	typedef enum logic [1:0] {
		PH_PREFIX,
		PH_FIRST,
		PH_BODY,
		PH_FAILED
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [23:0] acc_q, acc_n;
	logic [1:0]  pcnt_q, pcnt_n;
	logic [31:0] left_q, left_n;
	logic        idr_q, idr_n;
	logic [1:0]  fail_q, fail_n;

	logic [2:0]  nbytes;
	logic [31:0] len_full;
	logic [31:0] left_dec;
	logic [5:0]  nal_type;

	always_comb begin
		if (length_size == '0) begin
			nbytes = 3'd1;
		end else if (length_size > LEN_SIZE_MAX) begin
			nbytes = LEN_SIZE_MAX;
		end else begin
			nbytes = length_size;
		end
	end

	assign len_full = {acc_q, item.data_byte};
	assign left_dec = left_q - 32'd1;
	assign nal_type = item.data_byte[6:1];

	always_comb begin
		phase_n = phase_q;
		acc_n   = acc_q;
		pcnt_n  = pcnt_q;
		left_n  = left_q;
		idr_n   = idr_q;
		fail_n  = fail_q;
		case (phase_q)
			PH_PREFIX: begin
				if ({1'b0, pcnt_q} + 3'd1 >= nbytes) begin
					if (len_full < 32'd2) begin
						fail_n  = ST_BAD_LEN;
						phase_n = PH_FAILED;
					end else begin
						left_n  = len_full;
						phase_n = PH_FIRST;
					end
					acc_n  = '0;
					pcnt_n = '0;
				end else begin
					acc_n  = len_full[23:0];
					pcnt_n = pcnt_q + 2'd1;
				end
			end
			PH_FIRST: begin
				if (!nal_type[5]) begin
					if (nal_type == NAL_IDR_W_RADL || nal_type == NAL_IDR_N_LP) begin
						idr_n = 1'b1;
					end else begin
						fail_n = ST_NON_IDR;
					end
				end
				left_n = left_dec;
				if (left_dec == '0) begin
					phase_n = (fail_n != '0) ? PH_FAILED : PH_PREFIX;
				end else begin
					phase_n = PH_BODY;
				end
			end
			PH_BODY: begin
				left_n = left_dec;
				if (left_dec == '0) begin
					phase_n = (fail_q != '0) ? PH_FAILED : PH_PREFIX;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (phase_n == PH_FAILED) begin
			result.status = fail_n;
		end else if (phase_n != PH_PREFIX || pcnt_n != '0) begin
			result.status = ST_BAD_LEN;
		end else begin
			result.status = idr_n ? ST_IDR : ST_NO_VCL;
		end
		result.is_idr = (result.status == ST_IDR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			acc_q   <= '0;
			pcnt_q  <= '0;
			left_q  <= '0;
			idr_q   <= 1'b0;
			fail_q  <= '0;
		end else if (step) begin
			if (item.last_byte) begin
				phase_q <= PH_PREFIX;
				acc_q   <= '0;
				pcnt_q  <= '0;
				left_q  <= '0;
				idr_q   <= 1'b0;
				fail_q  <= '0;
			end else begin
				phase_q <= phase_n;
				acc_q   <= acc_n;
				pcnt_q  <= pcnt_n;
				left_q  <= left_n;
				idr_q   <= idr_n;
				fail_q  <= fail_n;
			end
		end
	end

	`HIAC_ASSERT(a_failed_has_code, (phase_q == PH_FAILED) |-> (fail_q != '0), "failed without code")
	`HIAC_ASSERT(a_body_has_left, (phase_q == PH_BODY || phase_q == PH_FIRST) |-> (left_q != '0), "payload count empty")
	`HIAC_ASSERT(a_prefix_in_range, (phase_q == PH_PREFIX) |-> ({1'b0, pcnt_q} < nbytes), "prefix count overrun")

endmodule

// ===== hw/rtl/hevc_idr_access_unit_checker_core.sv =====
// Top level of the HEVC IDR access unit checker
//
// Usage:
//   in_valid/in_ready/in_item carry one byte of a length-prefixed HEVC access
//   unit per item; in_item.last_byte marks the final byte of the unit.
//   out_valid/out_ready/out_item give one result per unit: is_idr and a
//   2-bit status (idr, no VCL NAL, non-IDR VCL NAL, bad or truncated length).
//   cfg_wr_en/cfg_wr_data set the NAL length prefix size (1 to 4 bytes,
//   0 acts as 1, above 4 acts as 4); write it only while the block is idle.
// Timing:
//   A byte is registered on acceptance and parsed in the following cycle,
//   unless it is a last byte held by a stall; parsing a last byte registers
//   its result. One byte per cycle is sustained unless a last byte stalls.
// Reset:
//   arst_n clears the parser state, drops out_valid and sets the prefix
//   size to 4. After every last byte the parser returns to its reset state.
// Stall:
//   While a result waits on out_ready, a further last byte waits in the
//   input register and in_ready falls; other bytes keep flowing.
module hevc_idr_access_unit_checker_core import hiac_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_wr_en,
	input  logic [LEN_SIZE_W-1:0] cfg_wr_data
);

	`include "hevc_idr_access_unit_checker_core_macros.svh"

	logic [LEN_SIZE_W-1:0] len_size_q;
	logic                  valid_s1;
	in_item_t              item_s1;
	logic                  out_free;
	logic                  fire_s1;
	out_item_t             result;
	out_item_t             out_item_q;
	logic                  out_valid_q;

	assign out_free = !out_valid_q || out_ready;
	assign fire_s1  = valid_s1 && (!item_s1.last_byte || out_free);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_size_q <= LEN_SIZE_RESET;
		end else if (cfg_wr_en) begin
			len_size_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	hiac_nal_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (fire_s1),
		.item        (item_s1),
		.length_size (len_size_q),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire_s1 && item_s1.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire_s1 && item_s1.last_byte) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`HIAC_ASSERT(a_result_from_last, $rose(out_valid_q) |-> $past(valid_s1 && item_s1.last_byte), "result without last byte")
	`HIAC_ASSERT(a_s1_holds, (valid_s1 && !fire_s1) |=> (valid_s1 && $stable(item_s1)), "input register lost item")
	`HIAC_NEVER(a_no_overrun, valid_s1 && item_s1.last_byte && out_valid_q && !out_ready && in_ready, "last byte overruns result")
	`HIAC_ASSERT(a_idr_matches, out_valid_q |-> (out_item_q.is_idr == (out_item_q.status == ST_IDR)), "is_idr and status disagree")

endmodule
